@@ rtl/bmpu_pkg.sv @@
// Shared types and constants for the BMP pixel unpacker.
// No dependencies; every other file of the block but bmpu_ram imports this package.
package bmpu_pkg;

  localparam int unsigned MAX_WIDTH         = 4096;
  localparam int unsigned MAX_HEIGHT        = 4096;
  localparam int unsigned PALETTE_DEPTH_DEF = 256;

  // APB byte address width for three 32-bit registers.
  localparam int unsigned CFG_AW = 4;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BPP    = 2'd2;

  // Supported pixel depths.
  localparam logic [5:0] BPP_1  = 6'd1;
  localparam logic [5:0] BPP_4  = 6'd4;
  localparam logic [5:0] BPP_8  = 6'd8;
  localparam logic [5:0] BPP_24 = 6'd24;

  localparam logic REQ_PALETTE = 1'b0;
  localparam logic REQ_IMAGE   = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_DEPTH = 1'b1;

  // Settings derived from the configuration registers.
  typedef struct packed {
    logic [12:0] width;      // min(image_width, MAX_WIDTH)
    logic [12:0] height;     // min(image_height, MAX_HEIGHT)
    logic [14:0] pad_len;    // padded row length in bytes
    logic [5:0]  bpp;
    logic        supported;
    logic        clear;      // register write: restart the image
  } cfg_t;

endpackage

@@ rtl/bmpu_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Read data holds while re_i is low. No dependencies.
module bmpu_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bmpu_cfg.sv @@
// APB configuration registers of the BMP pixel unpacker and the row
// settings derived from them. Depends on bmpu_pkg.
module bmpu_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bmpu_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output bmpu_pkg::cfg_t              cfg_o
);
  import bmpu_pkg::*;

  function automatic logic [14:0] pad_len(input logic [12:0] w, input logic [5:0] bpp);
    logic [17:0] prod;
    logic [18:0] sum;
    case (bpp)
      BPP_1:   prod = {5'b0, w};
      BPP_4:   prod = {3'b0, w, 2'b0};
      BPP_8:   prod = {2'b0, w, 3'b0};
      BPP_24:  prod = {1'b0, w, 4'b0} + {2'b0, w, 3'b0};
      default: prod = '0;
    endcase
    sum = {1'b0, prod} + 19'd31;
    // Row bits rounded up to whole 32-bit words, as bytes: a multiple of four.
    return {sum[17:5], 2'b00};
  endfunction

  logic [12:0] width_q, height_q;
  logic [5:0]  bpp_q;
  logic [12:0] width_eff_q, height_eff_q, width_eff_d, height_eff_d;
  logic [14:0] pad_len_q;
  logic        wr_en;
  logic [1:0]  wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1;
      height_q <= 13'd1;
      bpp_q    <= BPP_24;
    end else if (wr_en) begin
      case (wr_idx)
        REG_WIDTH:  width_q  <= pwdata[12:0];
        REG_HEIGHT: height_q <= pwdata[12:0];
        REG_BPP:    bpp_q    <= pwdata[5:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    width_eff_d  = width_q;
    height_eff_d = height_q;
    if (32'(width_q) > MAX_WIDTH) begin
      width_eff_d = 13'(MAX_WIDTH);
    end
    if (32'(height_q) > MAX_HEIGHT) begin
      height_eff_d = 13'(MAX_HEIGHT);
    end
  end

  // Derived values are registered; the user must write only while idle, unchecked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_eff_q  <= 13'd1;
      height_eff_q <= 13'd1;
      pad_len_q    <= pad_len(13'd1, BPP_24);
    end else begin
      width_eff_q  <= width_eff_d;
      height_eff_q <= height_eff_d;
      pad_len_q    <= pad_len(width_eff_d, bpp_q);
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = {19'b0, width_q};
      REG_HEIGHT: prdata = {19'b0, height_q};
      REG_BPP:    prdata = {26'b0, bpp_q};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.width     = width_eff_q;
    cfg_o.height    = height_eff_q;
    cfg_o.pad_len   = pad_len_q;
    cfg_o.bpp       = bpp_q;
    cfg_o.supported = (bpp_q == BPP_1) || (bpp_q == BPP_4) ||
                      (bpp_q == BPP_8) || (bpp_q == BPP_24);
    cfg_o.clear     = wr_en && (wr_idx == REG_WIDTH || wr_idx == REG_HEIGHT ||
                                wr_idx == REG_BPP);
  end

endmodule

@@ rtl/bmp_pixel_unpacker.sv @@
// Top level of the BMP pixel unpacker: byte stepper, palette RAM, output stage.
// Depends on bmpu_pkg, bmpu_cfg and bmpu_ram.
//
//   port group   direction  handshake            payload
//   in           to block   in_valid_i/in_stall_o req_type, data_byte, palette_*
//   out          from block out_valid_o/out_stall_i status, pixel_x/y, rgb, flags
//   cfg          to block   APB psel/penable      paddr, pwdata, prdata
//
// The stepper takes a word one pixel per step, and a word that yields no pixel
// still takes a step; a 1-bit byte yields up to eight pixels, 4-bit up to two,
// other depths at most one. The palette RAM's single read port sets the pace of
// one pixel per cycle while the output is not stalled. A result is registered
// into the output register at its step. Reset is immediate; the palette needs
// no clearing pass. A stalled output holds the stepper, which stalls the input.
module bmp_pixel_unpacker #(
  parameter int unsigned PALETTE_DEPTH = bmpu_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        req_type_i,
  input  logic [7:0]                  data_byte_i,
  input  logic [7:0]                  palette_index_i,
  input  logic [7:0]                  palette_red_i,
  input  logic [7:0]                  palette_green_i,
  input  logic [7:0]                  palette_blue_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        status_o,
  output logic [11:0]                 pixel_x_o,
  output logic [11:0]                 pixel_y_o,
  output logic [7:0]                  red_o,
  output logic [7:0]                  green_o,
  output logic [7:0]                  blue_o,
  output logic                        last_of_item_o,
  output logic                        end_of_image_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bmpu_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import bmpu_pkg::*;

  localparam int unsigned PAW = $clog2(PALETTE_DEPTH);

  localparam logic [1:0] PH_BLUE  = 2'd0;
  localparam logic [1:0] PH_GREEN = 2'd1;
  localparam logic [1:0] PH_RED   = 2'd2;

  cfg_t cfg;

  bmpu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stepper: the word being worked on.
  logic        a_valid_q;
  logic        a_type_q;
  logic [7:0]  a_byte_q;
  logic [7:0]  a_pidx_q;
  logic [23:0] a_prgb_q;
  logic [2:0]  a_sub_q, a_sub_d;

  // Image position.
  logic [12:0] col_q, col_d;
  logic [12:0] row_q, row_d;
  logic [14:0] rbc_q, rbc_d;
  logic [1:0]  phase_q, phase_d;
  logic [15:0] held_q, held_d;

  // Output register.
  logic        out_valid_q;
  logic        out_status_q;
  logic [11:0] out_x_q, out_y_q;
  logic        out_last_q, out_eoi_q, out_use_pal_q;
  logic [23:0] out_rgb_q;

  logic        in_accept, out_free, step_go;
  logic        needs_out, done, use_pal, last, eoi, status, pal_we;
  logic [7:0]  pal_idx;
  logic        pal_ok;
  logic [23:0] rgb;
  logic [13:0] col_inc, row_inc;
  logic [14:0] rbc_inc;
  logic        col_lt_w, col_more;
  logic [12:0] y_full;
  logic [23:0] ram_rdata;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign col_inc   = {1'b0, col_q} + 14'd1;
  assign row_inc   = {1'b0, row_q} + 14'd1;
  assign rbc_inc   = rbc_q + 15'd1;
  assign col_lt_w  = col_q < cfg.width;
  assign col_more  = col_inc < {1'b0, cfg.width};
  assign y_full    = cfg.height - 13'd1 - row_q;
  assign pal_ok    = {1'b0, pal_idx} < 9'(PALETTE_DEPTH);

  // One step of the current word: at most one result.
  always_comb begin
    needs_out = 1'b0;
    done      = 1'b1;
    use_pal   = 1'b0;
    pal_idx   = '0;
    rgb       = '0;
    status    = STATUS_OK;
    last      = 1'b1;
    eoi       = 1'b0;
    pal_we    = 1'b0;
    if (a_valid_q && a_type_q == REQ_PALETTE) begin
      pal_we = {1'b0, a_pidx_q} < 9'(PALETTE_DEPTH);
    end else if (a_valid_q) begin
      if (!cfg.supported) begin
        needs_out = 1'b1;
        status    = STATUS_BAD_DEPTH;
      end else if (col_lt_w) begin
        case (cfg.bpp)
          BPP_1: begin
            needs_out = 1'b1;
            pal_idx   = {7'b0, a_byte_q[3'd7 - a_sub_q]};
            done      = (a_sub_q == 3'd7) || !col_more;
          end
          BPP_4: begin
            needs_out = 1'b1;
            pal_idx   = a_sub_q[0] ? {4'b0, a_byte_q[3:0]} : {4'b0, a_byte_q[7:4]};
            done      = a_sub_q[0] || !col_more;
          end
          BPP_8: begin
            needs_out = 1'b1;
            pal_idx   = a_byte_q;
          end
          default: begin
            // 24-bit: only the red byte completes a pixel.
            if (phase_q != PH_BLUE && phase_q != PH_GREEN) begin
              needs_out = 1'b1;
              rgb       = {a_byte_q, held_q[7:0], held_q[15:8]};
            end
          end
        endcase
        use_pal = needs_out && (cfg.bpp != BPP_24) && pal_ok;
        last    = done;
        eoi     = (col_inc == {1'b0, cfg.width}) && (row_inc == {1'b0, cfg.height});
      end
    end
  end

  assign step_go    = a_valid_q && (!needs_out || out_free);
  assign in_stall_o = a_valid_q && !(step_go && done);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Position update.
  always_comb begin
    a_sub_d = a_sub_q;
    col_d   = col_q;
    row_d   = row_q;
    rbc_d   = rbc_q;
    phase_d = phase_q;
    held_d  = held_q;
    if (step_go && a_type_q == REQ_IMAGE && cfg.supported) begin
      if (!done) begin
        a_sub_d = a_sub_q + 3'd1;
      end
      if (col_lt_w) begin
        if (cfg.bpp == BPP_24) begin
          case (phase_q)
            PH_BLUE: begin
              held_d  = {a_byte_q, 8'h00};
              phase_d = PH_GREEN;
            end
            PH_GREEN: begin
              held_d  = {held_q[15:8], a_byte_q};
              phase_d = PH_RED;
            end
            default: begin
              held_d  = '0;
              phase_d = PH_BLUE;
              col_d   = col_inc[12:0];
            end
          endcase
        end else begin
          col_d = col_inc[12:0];
        end
      end
      if (done) begin
        rbc_d = rbc_inc;
        if (col_d >= cfg.width && rbc_inc >= cfg.pad_len) begin
          col_d   = '0;
          rbc_d   = '0;
          phase_d = PH_BLUE;
          row_d   = (row_inc >= {1'b0, cfg.height}) ? 13'd0 : row_inc[12:0];
        end
      end
    end
    if (in_accept) begin
      a_sub_d = '0;
    end
    if (cfg.clear) begin
      col_d   = '0;
      row_d   = '0;
      rbc_d   = '0;
      phase_d = PH_BLUE;
      held_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      a_sub_q     <= '0;
      col_q       <= '0;
      row_q       <= '0;
      rbc_q       <= '0;
      phase_q     <= PH_BLUE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      a_valid_q <= in_accept || (a_valid_q && !(step_go && done));
      a_sub_q   <= a_sub_d;
      col_q     <= col_d;
      row_q     <= row_d;
      rbc_q     <= rbc_d;
      phase_q   <= phase_d;
      held_q    <= held_d;
      if (out_free) begin
        out_valid_q <= step_go && needs_out;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_type_q <= req_type_i;
      a_byte_q <= data_byte_i;
      a_pidx_q <= palette_index_i;
      a_prgb_q <= {palette_red_i, palette_green_i, palette_blue_i};
    end
    if (step_go && needs_out) begin
      out_status_q  <= status;
      out_x_q       <= (status == STATUS_OK) ? col_q[11:0] : 12'd0;
      out_y_q       <= (status == STATUS_OK) ? y_full[11:0] : 12'd0;
      out_last_q    <= last;
      out_eoi_q     <= eoi;
      out_use_pal_q <= use_pal;
      out_rgb_q     <= rgb;
    end
  end

  // The palette read is issued with the step; its data lands with the
  // output register and holds there while the output is stalled.
  bmpu_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (step_go && pal_we),
    .waddr_i (a_pidx_q[PAW-1:0]),
    .wdata_i (a_prgb_q),
    .re_i    (step_go && use_pal),
    .raddr_i (pal_idx[PAW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign pixel_x_o      = out_x_q;
  assign pixel_y_o      = out_y_q;
  assign red_o          = out_use_pal_q ? ram_rdata[23:16] : out_rgb_q[23:16];
  assign green_o        = out_use_pal_q ? ram_rdata[15:8]  : out_rgb_q[15:8];
  assign blue_o         = out_use_pal_q ? ram_rdata[7:0]   : out_rgb_q[7:0];
  assign last_of_item_o = out_last_q;
  assign end_of_image_o = out_eoi_q;

endmodule

@@ rtl/bmpu_checker.sv @@
// Port-level checks for the BMP pixel unpacker and the bind that attaches them.
// Depends on bmpu_pkg and bmp_pixel_unpacker.
module bmpu_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        req_type_i,
  input logic [7:0]                  data_byte_i,
  input logic [7:0]                  palette_index_i,
  input logic [7:0]                  palette_red_i,
  input logic [7:0]                  palette_green_i,
  input logic [7:0]                  palette_blue_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        status_o,
  input logic [11:0]                 pixel_x_o,
  input logic [11:0]                 pixel_y_o,
  input logic [7:0]                  red_o,
  input logic [7:0]                  green_o,
  input logic [7:0]                  blue_o,
  input logic                        last_of_item_o,
  input logic                        end_of_image_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [bmpu_pkg::CFG_AW-1:0] paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata,
  input logic                        pready
);
  import bmpu_pkg::*;

  // A stalled input word stays on the ports unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i &&
      $stable({req_type_i, data_byte_i, palette_index_i, palette_red_i,
               palette_green_i, palette_blue_i}))
    else $error("stalled input word changed");

  // A stalled word keeps its payload, including palette data from the RAM.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable({status_o, pixel_x_o, pixel_y_o, red_o, green_o, blue_o,
               last_of_item_o, end_of_image_o}))
    else $error("stalled output word changed");

  // A depth error word carries nothing but its status and the last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_BAD_DEPTH |->
      last_of_item_o && !end_of_image_o && pixel_x_o == 12'd0 &&
      pixel_y_o == 12'd0 && red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0)
    else $error("depth error word has nonzero fields");

  // The final pixel of an image always closes its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_image_o |-> last_of_item_o && status_o == STATUS_OK)
    else $error("end of image without last of item");

  // A width write reads back on the next cycle at the same address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[3:2] == REG_WIDTH |=>
      (!$stable(paddr) || prdata[12:0] == $past(pwdata[12:0])))
    else $error("width register readback mismatch");

endmodule

bind bmp_pixel_unpacker bmpu_checker u_bmpu_checker (.*);

@@ sim/bmp_pixel_unpacker_tb.sv @@
// Self-checking testbench for the BMP pixel unpacker: drives palette and image words,
// predicts every pixel in a built-in model and checks the result stream.
// Depends on bmpu_pkg and the bmp_pixel_unpacker top level.
module bmp_pixel_unpacker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bmpu_pkg::*;

  // Depths the block rejects; used to exercise the error path.
  localparam logic [5:0] BPP_NONE = 6'd0;
  localparam logic [5:0] BPP_2    = 6'd2;
  localparam logic [5:0] BPP_16   = 6'd16;
  localparam logic [5:0] BPP_32   = 6'd32;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOLD_CYCLES = 200;

  typedef struct {
    logic       req;
    logic [7:0] data;
    logic [7:0] pal_idx;
    logic [7:0] pal_r;
    logic [7:0] pal_g;
    logic [7:0] pal_b;
  } word_t;

  typedef struct {
    logic        status;
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        last;
    logic        eoi;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        req_type_i = REQ_IMAGE;
  logic [7:0]  data_byte_i = 8'h00;
  logic [7:0]  palette_index_i = 8'h00;
  logic [7:0]  palette_red_i = 8'h00;
  logic [7:0]  palette_green_i = 8'h00;
  logic [7:0]  palette_blue_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        status_o;
  logic [11:0] pixel_x_o;
  logic [11:0] pixel_y_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic        last_of_item_o;
  logic        end_of_image_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  bmp_pixel_unpacker u_top (.*);

  always #5ns clk_i = ~clk_i;

  // Shadow of the block: registers, palette and scan position.
  logic [12:0] cfg_width = 13'd1;
  logic [12:0] cfg_height = 13'd1;
  logic [5:0]  cfg_bpp = BPP_24;
  logic [23:0] clut [256];
  logic [12:0] col = '0;
  logic [12:0] row = '0;
  logic [14:0] row_bytes = '0;
  logic [1:0]  comp_phase = '0;
  logic [15:0] held_bg = '0;

  word_t  word_q [$];
  pixel_t pixel_q [$];
  bit     pal_known [256];

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned n_words = 0;
  bit          quiet = 1'b0;
  logic        idle_ok;

  assign idle_ok = !quiet && ((cycles % 512) < 384);

  function automatic int unsigned clamp(logic [12:0] v, int unsigned lim);
    return (v > lim) ? lim : int'(v);
  endfunction

  function automatic int unsigned padded_row_bytes(int unsigned w, logic [5:0] bpp);
    return ((w * bpp + 31) >> 3) & ~32'd3;
  endfunction

  task automatic clear_position();
    col = '0;
    row = '0;
    row_bytes = '0;
    comp_phase = '0;
    held_bg = '0;
  endtask

  task automatic emit_pixel(logic [23:0] rgb);
    int unsigned w;
    int unsigned h;
    pixel_t p;
    w = clamp(cfg_width, MAX_WIDTH);
    h = clamp(cfg_height, MAX_HEIGHT);
    p.status = STATUS_OK;
    p.x = col[11:0];
    p.y = 12'(h - 1 - row);
    {p.r, p.g, p.b} = rgb;
    p.last = 1'b0;
    p.eoi = (col + 1 == w) && (row + 1 == h);
    pixel_q.push_back(p);
    col = col + 13'd1;
  endtask

  // Works out the pixels that one accepted word yields.
  task automatic unpack_byte(word_t wd);
    int unsigned w;
    int unsigned queued;
    pixel_t p;
    if (wd.req == REQ_PALETTE) begin
      clut[wd.pal_idx] = {wd.pal_r, wd.pal_g, wd.pal_b};
      return;
    end
    if (cfg_bpp != BPP_1 && cfg_bpp != BPP_4 && cfg_bpp != BPP_8 && cfg_bpp != BPP_24) begin
      p = '{STATUS_BAD_DEPTH, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0};
      pixel_q.push_back(p);
      return;
    end
    w = clamp(cfg_width, MAX_WIDTH);
    queued = pixel_q.size();
    if (col < w) begin
      case (cfg_bpp)
        BPP_1: begin
          for (int i = 0; i < 8 && col < w; i++) emit_pixel(clut[wd.data[7-i]]);
        end
        BPP_4: begin
          emit_pixel(clut[wd.data[7:4]]);
          if (col < w) emit_pixel(clut[wd.data[3:0]]);
        end
        BPP_8: begin
          emit_pixel(clut[wd.data]);
        end
        default: begin
          // Blue and green are held until the red byte completes the pixel.
          if (comp_phase == 2'd0) begin
            held_bg = {wd.data, 8'h00};
            comp_phase = 2'd1;
          end else if (comp_phase == 2'd1) begin
            held_bg[7:0] = wd.data;
            comp_phase = 2'd2;
          end else begin
            emit_pixel({wd.data, held_bg[7:0], held_bg[15:8]});
            comp_phase = 2'd0;
            held_bg = '0;
          end
        end
      endcase
    end
    row_bytes = row_bytes + 15'd1;
    if (col >= w && row_bytes >= padded_row_bytes(w, cfg_bpp)) begin
      col = '0;
      row_bytes = '0;
      comp_phase = '0;
      row = row + 13'd1;
      if (row >= clamp(cfg_height, MAX_HEIGHT)) row = '0;
    end
    if (pixel_q.size() > queued) begin
      p = pixel_q.pop_back();
      p.last = 1'b1;
      pixel_q.push_back(p);
    end
  endtask

  task automatic cmp(string name, logic [11:0] exp_v, logic [11:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic check_pixel();
    pixel_t e;
    if (pixel_q.size() == 0) begin
      $display("%0t: unexpected pixel x=%0h y=%0h status=%0h", $time, pixel_x_o, pixel_y_o,
               status_o);
      errors++;
      return;
    end
    e = pixel_q.pop_front();
    cmp("status", 12'(e.status), 12'(status_o));
    cmp("pixel_x", e.x, pixel_x_o);
    cmp("pixel_y", e.y, pixel_y_o);
    cmp("red", 12'(e.r), 12'(red_o));
    cmp("green", 12'(e.g), 12'(green_o));
    cmp("blue", 12'(e.b), 12'(blue_o));
    cmp("last_of_item", 12'(e.last), 12'(last_of_item_o));
    cmp("end_of_image", 12'(e.eoi), 12'(end_of_image_o));
  endtask

  // Sender: offers queued words, with random gaps between them.
  word_t       cur_word;
  int unsigned send_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) unpack_byte(cur_word);
      if (in_valid_i && in_stall_o) begin
        // Hold the stalled word as it is.
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (word_q.size() != 0) begin
        cur_word = word_q.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= cur_word.req;
        data_byte_i <= cur_word.data;
        palette_index_i <= cur_word.pal_idx;
        palette_red_i <= cur_word.pal_r;
        palette_green_i <= cur_word.pal_g;
        palette_blue_i <= cur_word.pal_b;
        if (idle_ok && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 6);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: checks each pixel and stalls in random bursts, once for a long stretch
  // that starts while the sender still has words to offer.
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned pixels_seen = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_pixel();
        pixels_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && !quiet && pixels_seen >= 150 && word_q.size() >= 4) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_ok && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bmp_pixel_unpacker_tb NOT OK");
      $finish;
    end
  end

  // Stimulus helpers.
  task automatic push_word(word_t wd);
    word_q.push_back(wd);
    n_words++;
  endtask

  task automatic add_palette(logic [7:0] idx, logic [23:0] rgb);
    word_t wd;
    wd = '{REQ_PALETTE, 8'($urandom), idx, rgb[23:16], rgb[15:8], rgb[7:0]};
    pal_known[idx] = 1'b1;
    push_word(wd);
  endtask

  task automatic add_byte(logic [7:0] data);
    word_t wd;
    wd = '{REQ_IMAGE, data, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
    push_word(wd);
  endtask

  function automatic logic [7:0] known_index(int unsigned span);
    logic [7:0] k;
    repeat (64) begin
      k = 8'($urandom_range(0, span - 1));
      if (pal_known[k]) return k;
    end
    return 8'd0;
  endfunction

  // Palette depths only ever look up entries that were written before.
  function automatic logic [7:0] safe_byte(logic [5:0] bpp);
    logic [7:0] v;
    logic [7:0] hi;
    logic [7:0] lo;
    v = 8'($urandom);
    if (bpp == BPP_4) begin
      hi = known_index(16);
      lo = known_index(16);
      v = {hi[3:0], lo[3:0]};
    end else if (bpp == BPP_8) begin
      v = known_index(256);
    end
    return v;
  endfunction

  task automatic add_image(int unsigned n, logic [5:0] bpp);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) add_palette(8'($urandom), 24'($urandom));
      add_byte(safe_byte(bpp));
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (word_q.size() != 0 || in_valid_i || pixel_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WIDTH:  cfg_width = val[12:0];
      REG_HEIGHT: cfg_height = val[12:0];
      REG_BPP:    cfg_bpp = val[5:0];
      default: ;
    endcase
    clear_position();
  endtask

  task automatic set_image(logic [12:0] w, logic [12:0] h, logic [5:0] bpp);
    wait_drained();
    write_reg(REG_WIDTH, 32'(w));
    write_reg(REG_HEIGHT, 32'(h));
    write_reg(REG_BPP, 32'(bpp));
    @(negedge clk_i);
  endtask

  task automatic random_image(bit whole);
    logic [5:0]  bpp;
    logic [12:0] w;
    logic [12:0] h;
    int unsigned n;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) bpp = BPP_1;
    else if (pick < 5) bpp = BPP_4;
    else if (pick < 7) bpp = BPP_8;
    else if (pick < 9) bpp = BPP_24;
    else begin
      case ($urandom_range(0, 3))
        0: bpp = BPP_NONE;
        1: bpp = BPP_2;
        2: bpp = BPP_16;
        default: bpp = BPP_32;
      endcase
    end
    w = (bpp == BPP_24) ? 13'($urandom_range(1, 4)) : 13'($urandom_range(1, 24));
    h = 13'($urandom_range(1, 3));
    n = padded_row_bytes(32'(w), bpp) * 32'(h);
    if (!whole) n = n * $urandom_range(1, 2) + $urandom_range(0, 3);
    if (n > 40) n = 40;
    if (n == 0) n = 3;
    set_image(w, h, bpp);
    add_image(n, bpp);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: one 24-bit pixel and its padding byte under the reset settings.
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'hA5);
    add_byte(8'h5A);
    add_palette(8'd0, 24'hFF00FF);
    add_palette(8'd1, 24'h00FF00);
    add_palette(8'd2, 24'h000000);
    add_palette(8'd3, 24'hFFFFFF);
    add_palette(8'd15, 24'h123456);
    add_palette(8'd255, 24'hA5C35A);
    // 1-bit rows: a full byte, a partial byte, then padding.
    set_image(13'd10, 13'd2, BPP_1);
    add_byte(8'hA5);
    add_byte(8'hC0);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h55);
    add_byte(8'hAA);
    // 4-bit row whose last byte only uses the high nibble.
    set_image(13'd3, 13'd1, BPP_4);
    add_byte(8'h0F);
    add_byte(8'h21);
    add_byte(8'hFF);
    add_byte(8'h00);

    // Fixed settings: supported depths, rejected depths, zero width, largest sizes.
    set_image(13'd5, 13'd1, BPP_8);
    add_image(10, BPP_8);
    set_image(13'd2, 13'd2, BPP_24);
    add_image(19, BPP_24);
    set_image(13'd4, 13'd2, BPP_NONE);
    add_image(3, BPP_NONE);
    set_image(13'd4, 13'd2, BPP_2);
    add_image(2, BPP_2);
    set_image(13'd4, 13'd2, BPP_16);
    add_image(2, BPP_16);
    set_image(13'd4, 13'd2, BPP_32);
    add_image(3, BPP_32);
    set_image(13'd0, 13'd3, BPP_8);
    add_image(5, BPP_8);
    set_image(13'd0, 13'd0, BPP_24);
    add_image(3, BPP_24);
    set_image(13'h1FFF, 13'h1FFF, BPP_1);
    add_image(30, BPP_1);
    set_image(13'd4096, 13'd4096, BPP_24);
    add_image(9, BPP_24);
    set_image(13'd1, 13'd4096, BPP_8);
    add_image(12, BPP_8);

    // Random images, each fed once or twice over plus up to three bytes, at most 40 bytes.
    while (n_words < 250) random_image(1'b0);

    // Last stretch runs without any idling.
    wait_drained();
    quiet = 1'b1;
    random_image(1'b1);
    random_image(1'b1);

    wait_drained();
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("bmp_pixel_unpacker_tb OK");
    end else begin
      $display("bmp_pixel_unpacker_tb NOT OK");
    end
    $finish;
  end

endmodule
